FILE: hdl/pwtm_pkg.sv
// ----------------------------------------------------------------------------
// pwtm_pkg
// Shared types and constants of the polyphonic wavetable mixer: request and
// waveform codes, engine states, register map and fixed field widths.
// ----------------------------------------------------------------------------
package pwtm_pkg;

   typedef enum logic [1:0] {
      REQ_TICK     = 2'd0,
      REQ_NOTE_ON  = 2'd1,
      REQ_NOTE_OFF = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      WAVE_SAW      = 2'd0,
      WAVE_SINE     = 2'd1,
      WAVE_SQUARE   = 2'd2,
      WAVE_TRIANGLE = 2'd3
   } wave_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } engine_state_type;

   // field widths fixed by the interface
   localparam int REQ_TYPE_BITS  = 2;
   localparam int OCTAVE_BITS    = 3;
   localparam int SEMITONE_BITS  = 4;
   localparam int STEP_PORT_BITS = 32;
   localparam int SAMPLE_BITS    = 8;
   localparam int VOLUME_BITS    = 4;

   localparam int SEMITONES = 12;
   localparam logic [SEMITONE_BITS-1:0] SEMITONE_LIMIT = 4'd12;
   localparam logic [VOLUME_BITS-1:0]   VOLUME_TOP     = 4'd9;
   localparam logic [SAMPLE_BITS-1:0]   SAMPLE_MAX     = 8'hFF;

   // register map, one 32-bit word per register
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [1:0] CSR_WAVE   = 2'd0;
   localparam logic [1:0] CSR_VOLUME = 2'd1;
   localparam logic [1:0] CSR_MUTE   = 2'd2;

   localparam wave_type                WAVE_RESET   = WAVE_SINE;
   localparam logic [VOLUME_BITS-1:0]  VOLUME_RESET = 4'd5;

   // queue depths between the parts
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   // fixed-point constants for the sine table (Q62)
   localparam logic [63:0] Q62_HALF_PI = 64'h6487ED5110B4611A;
   localparam logic [63:0] Q62_ONE     = 64'h4000000000000000;

endpackage

FILE: hdl/pwtm_fifo.sv
// ----------------------------------------------------------------------------
// pwtm_fifo
// Small first-in first-out queue of register slots with full and empty flags.
// ----------------------------------------------------------------------------
module pwtm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PtrBits   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountBits = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     slot_ff [DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   always_comb begin
      full    = (count_ff == CountBits'(DEPTH));
      empty   = (count_ff == '0);
      rd_data = slot_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop  = pop && !empty;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: hdl/pwtm_front.sv
// ----------------------------------------------------------------------------
// pwtm_front
// Request front end: takes requests, works out the voice number, drops
// requests that do nothing and queues the rest as commands for the engine.
// ----------------------------------------------------------------------------
module pwtm_front #(
   parameter int NUM_OCTAVES = 8,
   parameter int PHASE_BITS  = 32
) (
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [pwtm_pkg::REQ_TYPE_BITS-1:0]   req_type,
   input  logic [pwtm_pkg::OCTAVE_BITS-1:0]     req_octave,
   input  logic [pwtm_pkg::SEMITONE_BITS-1:0]   req_semitone,
   input  logic [pwtm_pkg::STEP_PORT_BITS-1:0]  req_phase_step,
   input  logic                                 mute,
   input  logic                                 cmd_full,
   output logic                                 cmd_push,
   output logic [pwtm_pkg::REQ_TYPE_BITS+$clog2(NUM_OCTAVES*12)+PHASE_BITS-1:0] cmd_data
);

   import pwtm_pkg::*;

   localparam int Voices    = NUM_OCTAVES * SEMITONES;
   localparam int VoiceBits = $clog2(Voices);
   localparam int WideBits  = 7;

   logic                accept;
   logic                in_range;
   logic [WideBits-1:0] voice_wide;

   always_comb begin
      accept     = req_push && !cmd_full;
      req_full   = cmd_full;
      // octave * 12 + semitone
      voice_wide = WideBits'({req_octave, 3'b000}) + WideBits'({req_octave, 2'b00})
                 + WideBits'(req_semitone);
      in_range   = ({1'b0, req_octave} < 4'(NUM_OCTAVES)) && (req_semitone < SEMITONE_LIMIT);
      cmd_data   = {req_type, voice_wide[VoiceBits-1:0], req_phase_step[PHASE_BITS-1:0]};

      unique case (req_type) inside
         REQ_TICK:                  cmd_push = accept && !mute;
         REQ_NOTE_ON, REQ_NOTE_OFF: cmd_push = accept && in_range;
         default:                   cmd_push = 1'b0;
      endcase
   end

endmodule

FILE: hdl/pwtm_wave_rom.sv
// ----------------------------------------------------------------------------
// pwtm_wave_rom
// Four waveform tables (sawtooth, sine, square, triangle) built at
// elaboration, with a registered read of the selected table.
// ----------------------------------------------------------------------------
module pwtm_wave_rom #(
   parameter int LUT_ADDR_BITS = 8
) (
   input  logic                               clock,
   input  pwtm_pkg::wave_type                 wave_sel,
   input  logic [LUT_ADDR_BITS-1:0]           addr,
   output logic [pwtm_pkg::SAMPLE_BITS-1:0]   data
);

   import pwtm_pkg::*;

   localparam int          Entries   = 1 << LUT_ADDR_BITS;
   localparam int          TableBits = Entries * SAMPLE_BITS;
   localparam logic [63:0] Half      = 64'(Entries / 2);
   localparam logic [63:0] Quarter   = 64'(Entries / 4);
   localparam logic [63:0] Full      = 64'(Entries);

   // (a * b) >> 62 over a full 128-bit product
   function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // sin(pi/2 * j / Quarter) in Q62 by its Taylor series
   function automatic logic [63:0] quarter_sine(logic [63:0] j);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      if (j == 64'd0) begin
         return 64'd0;
      end
      if (j >= Quarter) begin
         return Q62_ONE;
      end
      x    = (Q62_HALF_PI / Quarter) * j + ((Q62_HALF_PI % Quarter) * j) / Quarter;
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int k = 2; k < 60; k += 2) begin
         if (term != 64'd0) begin
            term = mul_q62(term, x2) / 64'(k * (k + 1));
            if ((k & 2) != 0) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
      end
      return sum;
   endfunction

   function automatic logic [TableBits-1:0] build_table(wave_type sel);
      logic [TableBits-1:0] t;
      logic [63:0]          i;
      logic [63:0]          s;
      logic [63:0]          v;
      logic                 neg;
      t = '0;
      for (int n = 0; n < Entries; n++) begin
         i   = 64'(n);
         s   = 64'd0;
         neg = 1'b0;
         unique case (sel)
            WAVE_SAW:    v = (i * 64'd255) >> LUT_ADDR_BITS;
            WAVE_SQUARE: v = (i < Half) ? 64'd0 : 64'd255;
            WAVE_TRIANGLE: begin
               v = (i < Half) ? (i * 64'd255) / Half : ((Full - i) * 64'd255) / Half;
            end
            default: begin
               if (i <= Quarter) begin
                  s = quarter_sine(i);
               end else if (i <= Half) begin
                  s = quarter_sine(Half - i);
               end else if (i <= 3 * Quarter) begin
                  s = quarter_sine(i - Half);
                  neg = 1'b1;
               end else begin
                  s = quarter_sine(Full - i);
                  neg = 1'b1;
               end
               s = s >> 8;
               v = neg ? ((64'd1 << 54) - s) : ((64'd1 << 54) + s);
               v = (v * 64'd255) >> 55;
            end
         endcase
         t[n*SAMPLE_BITS +: SAMPLE_BITS] = v[SAMPLE_BITS-1:0];
      end
      return t;
   endfunction

   localparam logic [TableBits-1:0] SawRom      = build_table(WAVE_SAW);
   localparam logic [TableBits-1:0] SineRom     = build_table(WAVE_SINE);
   localparam logic [TableBits-1:0] SquareRom   = build_table(WAVE_SQUARE);
   localparam logic [TableBits-1:0] TriangleRom = build_table(WAVE_TRIANGLE);

   logic [LUT_ADDR_BITS+2:0] bit_pos;

   assign bit_pos = {addr, 3'b000};

   always_ff @(posedge clock) begin
      unique case (wave_sel)
         WAVE_SAW:      data <= SawRom[bit_pos +: SAMPLE_BITS];
         WAVE_SINE:     data <= SineRom[bit_pos +: SAMPLE_BITS];
         WAVE_SQUARE:   data <= SquareRom[bit_pos +: SAMPLE_BITS];
         WAVE_TRIANGLE: data <= TriangleRom[bit_pos +: SAMPLE_BITS];
         default:       data <= SineRom[bit_pos +: SAMPLE_BITS];
      endcase
   end

endmodule

FILE: hdl/pwtm_engine.sv
// ----------------------------------------------------------------------------
// pwtm_engine
// Voice engine: applies note commands to the voice state and, for a tick,
// walks all voices one per cycle through a three-stage pipeline (memory read,
// phase add and table read, scale and sum), then emits the saturated sum.
// ----------------------------------------------------------------------------
module pwtm_engine #(
   parameter int LUT_ADDR_BITS = 8,
   parameter int NUM_OCTAVES   = 8,
   parameter int PHASE_BITS    = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cmd_empty,
   input  logic [pwtm_pkg::REQ_TYPE_BITS+$clog2(NUM_OCTAVES*12)+PHASE_BITS-1:0] cmd_data,
   output logic                                 cmd_pop,
   input  pwtm_pkg::wave_type                   wave_sel,
   input  logic [pwtm_pkg::VOLUME_BITS-1:0]     volume,
   input  logic                                 out_full,
   output logic                                 out_push,
   output logic [pwtm_pkg::SAMPLE_BITS-1:0]     out_sample
);

   import pwtm_pkg::*;

   localparam int Voices    = NUM_OCTAVES * SEMITONES;
   localparam int VoiceBits = $clog2(Voices);
   localparam int CmdBits   = REQ_TYPE_BITS + VoiceBits + PHASE_BITS;
   localparam int SumBits   = $clog2(Voices * 255 + 1);

   engine_state_type       state_ff, state_in;
   logic [VoiceBits-1:0]   walk_ff, walk_in;
   logic [SumBits-1:0]     sum_ff, sum_in;
   logic [Voices-1:0]      active_ff, active_in;
   logic [Voices-1:0]      acc_valid_ff, acc_valid_in;

   logic [PHASE_BITS-1:0]  acc_mem_ff  [Voices];
   logic [PHASE_BITS-1:0]  step_mem_ff [Voices];
   logic [PHASE_BITS-1:0]  acc_rd_ff;
   logic [PHASE_BITS-1:0]  step_rd_ff;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_active_ff;
   logic                   s1_acc_valid_ff;
   logic [VoiceBits-1:0]   s1_voice_ff;
   logic                   s2_valid_ff;
   logic                   s2_active_ff;

   req_kind_type           cmd_kind;
   logic [VoiceBits-1:0]   cmd_voice;
   logic [PHASE_BITS-1:0]  cmd_step;
   logic                   step_we;
   logic                   acc_we;
   logic [PHASE_BITS-1:0]  acc_new;
   logic [SAMPLE_BITS-1:0] rom_data;
   logic [VOLUME_BITS-1:0] shift_amt;

   assign cmd_kind  = req_kind_type'(cmd_data[CmdBits-1 -: REQ_TYPE_BITS]);
   assign cmd_voice = cmd_data[PHASE_BITS +: VoiceBits];
   assign cmd_step  = cmd_data[PHASE_BITS-1:0];
   assign shift_amt = (volume >= VOLUME_TOP) ? '0 : VOLUME_TOP - volume;
   assign acc_new   = (s1_acc_valid_ff ? acc_rd_ff : '0) + step_rd_ff;
   assign acc_we    = s1_valid_ff && s1_active_ff;
   assign out_sample = (sum_ff > SumBits'(SAMPLE_MAX)) ? SAMPLE_MAX : sum_ff[SAMPLE_BITS-1:0];

   pwtm_wave_rom #(
      .LUT_ADDR_BITS (LUT_ADDR_BITS)
   ) u_rom (
      .clock    (clock),
      .wave_sel (wave_sel),
      .addr     (acc_new[PHASE_BITS-1 -: LUT_ADDR_BITS]),
      .data     (rom_data)
   );

   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      sum_in       = sum_ff;
      active_in    = active_ff;
      acc_valid_in = acc_valid_ff;
      s1_valid_in  = 1'b0;
      cmd_pop      = 1'b0;
      out_push     = 1'b0;
      step_we      = 1'b0;

      if (acc_we) begin
         acc_valid_in[s1_voice_ff] = 1'b1;
      end
      if (s2_valid_ff && s2_active_ff) begin
         sum_in = sum_ff + SumBits'(rom_data >> shift_amt);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               unique case (cmd_kind)
                  REQ_TICK: begin
                     walk_in  = '0;
                     sum_in   = '0;
                     state_in = ST_WALK;
                  end
                  REQ_NOTE_ON: begin
                     active_in[cmd_voice] = 1'b1;
                     step_we = 1'b1;
                  end
                  REQ_NOTE_OFF: begin
                     active_in[cmd_voice] = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            s1_valid_in = 1'b1;
            if (walk_ff == VoiceBits'(Voices - 1)) begin
               state_in = ST_FLUSH;
            end else begin
               walk_in = walk_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            // hold until the last voice has been summed and the result queue has room
            if (!s1_valid_ff && !s2_valid_ff && !out_full) begin
               out_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         walk_ff      <= '0;
         sum_ff       <= '0;
         active_ff    <= '0;
         acc_valid_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         sum_ff       <= sum_in;
         active_ff    <= active_in;
         acc_valid_ff <= acc_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_voice_ff     <= walk_ff;
      s1_active_ff    <= active_ff[walk_ff];
      s1_acc_valid_ff <= acc_valid_ff[walk_ff];
      s2_active_ff    <= s1_active_ff;
   end

   always_ff @(posedge clock) begin
      acc_rd_ff <= acc_mem_ff[walk_ff];
      if (acc_we) begin
         acc_mem_ff[s1_voice_ff] <= acc_new;
      end
   end

   always_ff @(posedge clock) begin
      step_rd_ff <= step_mem_ff[walk_ff];
      if (step_we) begin
         step_mem_ff[cmd_voice] <= cmd_step;
      end
   end

endmodule

FILE: hdl/polyphonic_wavetable_mixer_core.sv
// ----------------------------------------------------------------------------
// polyphonic_wavetable_mixer_core
// Polyphonic wavetable oscillator bank with a queue interface on both sides
// and a register port for waveform, volume and mute.
// ----------------------------------------------------------------------------
// A note request is applied in the engine's idle state without leaving it. A tick
// request walks all NUM_OCTAVES*12 voices one per cycle through the phase
// accumulator memory, and the engine takes no further command until the tick's
// sample has entered the result queue, which waits for room in that queue.
// Requests enter a four-deep command queue, so the request side keeps accepting
// while a tick is in progress until it is full; results wait in a two-deep queue.
// Muted ticks, unknown request codes and notes outside the voice range are
// accepted and dropped without reaching the engine.
// ----------------------------------------------------------------------------
module polyphonic_wavetable_mixer_core #(
   parameter int LUT_ADDR_BITS = 8,
   parameter int NUM_OCTAVES   = 8,
   parameter int PHASE_BITS    = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [pwtm_pkg::REQ_TYPE_BITS-1:0]   req_type,
   input  logic [pwtm_pkg::OCTAVE_BITS-1:0]     req_octave,
   input  logic [pwtm_pkg::SEMITONE_BITS-1:0]   req_semitone,
   input  logic [pwtm_pkg::STEP_PORT_BITS-1:0]  req_phase_step,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [pwtm_pkg::SAMPLE_BITS-1:0]     rsp_sample,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pwtm_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [pwtm_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [pwtm_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   import pwtm_pkg::*;

   localparam int Voices    = NUM_OCTAVES * SEMITONES;
   localparam int VoiceBits = $clog2(Voices);
   localparam int CmdBits   = REQ_TYPE_BITS + VoiceBits + PHASE_BITS;

   wave_type               wave_ff, wave_in;
   logic [VOLUME_BITS-1:0] volume_ff, volume_in;
   logic                   mute_ff, mute_in;
   logic                   csr_write;

   logic                   cmd_push;
   logic                   cmd_full;
   logic                   cmd_pop;
   logic                   cmd_empty;
   logic [CmdBits-1:0]     cmd_wr_data;
   logic [CmdBits-1:0]     cmd_rd_data;

   logic                   out_push;
   logic                   out_full;
   logic [SAMPLE_BITS-1:0] out_sample;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      wave_in   = wave_ff;
      volume_in = volume_ff;
      mute_in   = mute_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            CSR_WAVE:   wave_in   = wave_type'(csr_pwdata[1:0]);
            CSR_VOLUME: volume_in = csr_pwdata[VOLUME_BITS-1:0];
            CSR_MUTE:   mute_in   = csr_pwdata[0];
            default: ;
         endcase
      end
      unique case (csr_paddr[3:2])
         CSR_WAVE:   csr_prdata = CSR_DATA_BITS'(wave_ff);
         CSR_VOLUME: csr_prdata = CSR_DATA_BITS'(volume_ff);
         CSR_MUTE:   csr_prdata = CSR_DATA_BITS'(mute_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff   <= WAVE_RESET;
         volume_ff <= VOLUME_RESET;
         mute_ff   <= 1'b0;
      end else begin
         wave_ff   <= wave_in;
         volume_ff <= volume_in;
         mute_ff   <= mute_in;
      end
   end

   pwtm_front #(
      .NUM_OCTAVES (NUM_OCTAVES),
      .PHASE_BITS  (PHASE_BITS)
   ) u_front (
      .req_push       (req_push),
      .req_full       (req_full),
      .req_type       (req_type),
      .req_octave     (req_octave),
      .req_semitone   (req_semitone),
      .req_phase_step (req_phase_step),
      .mute           (mute_ff),
      .cmd_full       (cmd_full),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_wr_data)
   );

   pwtm_fifo #(
      .WIDTH (CmdBits),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr_data),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd_data),
      .empty   (cmd_empty)
   );

   pwtm_engine #(
      .LUT_ADDR_BITS (LUT_ADDR_BITS),
      .NUM_OCTAVES   (NUM_OCTAVES),
      .PHASE_BITS    (PHASE_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_empty  (cmd_empty),
      .cmd_data   (cmd_rd_data),
      .cmd_pop    (cmd_pop),
      .wave_sel   (wave_ff),
      .volume     (volume_ff),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_sample (out_sample)
   );

   pwtm_fifo #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_sample),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (rsp_sample),
      .empty   (rsp_empty)
   );

   // the engine never offers a sample the result queue cannot take
   a_no_rsp_overflow : assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("engine pushed a sample into a full result queue");

   // a tick transfer while muted never reaches the engine
   a_muted_tick_dropped : assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && (req_type == REQ_TICK) && mute_ff) |-> !cmd_push)
      else $error("muted tick was queued");

   // no result is waiting right after reset
   a_empty_after_reset : assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result queue not empty after reset");

   // the engine pops the command queue only while it holds a command
   a_pop_only_when_present : assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("engine popped an empty command queue");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the polyphonic wavetable mixer core. Requests
// go in through the request queue port and register settings through the
// register port. A model of the voice bank predicts every tick
// sample, and each popped sample is compared in order against the queue of
// predicted samples. Directed note and register cases run first, then
// random segments under changing idle patterns and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
   import pwtm_pkg::*;

   localparam int WAVE_ADDR_W  = 8;
   localparam int NUM_OCT      = 8;
   localparam int PHASE_W      = 32;
   localparam int WAVE_ENTRIES = 1 << WAVE_ADDR_W;
   localparam int LUT_HALF     = WAVE_ENTRIES / 2;
   localparam int LUT_QUARTER  = WAVE_ENTRIES / 4;
   localparam int VOICE_COUNT  = NUM_OCT * SEMITONES;
   localparam int DRAIN_CYCLES = 2 * (VOICE_COUNT + 4);
   localparam int STALL_LIMIT  = 5000;
   localparam int SEGMENT_ITEMS = 104;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [REQ_TYPE_BITS-1:0]  kind;
      logic [OCTAVE_BITS-1:0]    octave;
      logic [SEMITONE_BITS-1:0]  semitone;
      logic [STEP_PORT_BITS-1:0] step;
   } mixer_req_type;

   logic                        clock;
   logic                        reset;
   logic                        req_push;
   logic                        req_full;
   logic [REQ_TYPE_BITS-1:0]    req_type;
   logic [OCTAVE_BITS-1:0]      req_octave;
   logic [SEMITONE_BITS-1:0]    req_semitone;
   logic [STEP_PORT_BITS-1:0]   req_phase_step;
   logic                        rsp_empty;
   logic                        rsp_pop;
   logic [SAMPLE_BITS-1:0]      rsp_sample;
   logic                        csr_psel;
   logic                        csr_penable;
   logic                        csr_pwrite;
   logic [CSR_ADDR_BITS-1:0]    csr_paddr;
   logic [CSR_DATA_BITS-1:0]    csr_pwdata;
   logic [CSR_DATA_BITS-1:0]    csr_prdata;
   logic                        csr_pready;

   // voice bank model
   logic [7:0]          saw_lut    [WAVE_ENTRIES];
   logic [7:0]          sine_lut   [WAVE_ENTRIES];
   logic [7:0]          square_lut [WAVE_ENTRIES];
   logic [7:0]          tri_lut    [WAVE_ENTRIES];
   logic [PHASE_W-1:0]  phase_acc  [VOICE_COUNT];
   logic [PHASE_W-1:0]  phase_inc  [VOICE_COUNT];
   bit                  voice_on   [VOICE_COUNT];
   wave_type            wave_cfg;
   logic [VOLUME_BITS-1:0] volume_cfg;
   logic                mute_cfg;

   logic [SAMPLE_BITS-1:0] expected_samples[$];
   int mismatch_count;
   int send_idle_pct;
   int recv_idle_pct;
   int pop_hold_left;

   polyphonic_wavetable_mixer_core #(
      .LUT_ADDR_BITS (WAVE_ADDR_W),
      .NUM_OCTAVES   (NUM_OCT),
      .PHASE_BITS    (PHASE_W)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_type       (req_type),
      .req_octave     (req_octave),
      .req_semitone   (req_semitone),
      .req_phase_step (req_phase_step),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_sample     (rsp_sample),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // (a*b) >> 62 on a full 128-bit product
   function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
   endfunction

   // sin(pi/2 * j/q) in Q62 by Taylor series
   function automatic logic [63:0] quarter_sin(input logic [63:0] j, input logic [63:0] q);
      logic [63:0] x, x2, term, acc;
      if (j == 64'd0) return 64'd0;
      if (j >= q) return Q62_ONE;
      x = (Q62_HALF_PI / q) * j + ((Q62_HALF_PI % q) * j) / q;
      x2 = q62_mul(x, x);
      term = x;
      acc = x;
      for (int k = 2; k < 60 && term != 64'd0; k += 2) begin
         term = q62_mul(term, x2) / 64'(k * (k + 1));
         if ((k & 2) != 0) acc = acc - term;
         else acc = acc + term;
      end
      return acc;
   endfunction

   initial begin
      logic [63:0] s, v;
      int j;
      bit neg;
      for (int i = 0; i < WAVE_ENTRIES; i++) begin
         saw_lut[i]    = 8'((i * 255) >> WAVE_ADDR_W);
         square_lut[i] = (i < LUT_HALF) ? 8'd0 : 8'd255;
         tri_lut[i]    = (i < LUT_HALF) ? 8'((i * 255) / LUT_HALF)
                                        : 8'(((WAVE_ENTRIES - i) * 255) / LUT_HALF);
         if (i <= LUT_QUARTER) begin
            j = i;
            neg = 1'b0;
         end else if (i <= LUT_HALF) begin
            j = LUT_HALF - i;
            neg = 1'b0;
         end else if (i <= 3 * LUT_QUARTER) begin
            j = i - LUT_HALF;
            neg = 1'b1;
         end else begin
            j = WAVE_ENTRIES - i;
            neg = 1'b1;
         end
         s = quarter_sin(64'(j), 64'(LUT_QUARTER)) >> 8;
         v = neg ? (64'd1 << 54) - s : (64'd1 << 54) + s;
         sine_lut[i] = 8'((v * 64'd255) >> 55);
      end
   end

   // Apply one request to the voice bank; return 1 when it yields a sample.
   function automatic bit mix_request(input mixer_req_type r, output logic [7:0] sample);
      int voice;
      int shift;
      int unsigned total;
      logic [WAVE_ADDR_W-1:0] idx;
      logic [7:0] lut_val;
      sample = '0;
      if (r.kind == REQ_NOTE_ON || r.kind == REQ_NOTE_OFF) begin
         if (r.octave >= NUM_OCT || r.semitone >= SEMITONE_LIMIT) return 1'b0;
         voice = r.octave * SEMITONES + r.semitone;
         if (r.kind == REQ_NOTE_ON) begin
            voice_on[voice]  = 1'b1;
            phase_inc[voice] = r.step[PHASE_W-1:0];
         end else begin
            voice_on[voice] = 1'b0;
         end
         return 1'b0;
      end
      if (r.kind != REQ_TICK || mute_cfg) return 1'b0;
      shift = (volume_cfg >= VOLUME_TOP) ? 0 : int'(VOLUME_TOP) - int'(volume_cfg);
      total = 0;
      for (int n = 0; n < VOICE_COUNT; n++) begin
         if (voice_on[n]) begin
            phase_acc[n] = phase_acc[n] + phase_inc[n];
            idx = phase_acc[n][PHASE_W-1 -: WAVE_ADDR_W];
            case (wave_cfg)
               WAVE_SAW:      lut_val = saw_lut[idx];
               WAVE_SQUARE:   lut_val = square_lut[idx];
               WAVE_TRIANGLE: lut_val = tri_lut[idx];
               default:       lut_val = sine_lut[idx];
            endcase
            total += lut_val >> shift;
         end
      end
      sample = (total > SAMPLE_MAX) ? SAMPLE_MAX : 8'(total);
      return 1'b1;
   endfunction

   function automatic mixer_req_type make_req(input logic [1:0] kind, input int oct,
                                              input int semi, input logic [31:0] step);
      mixer_req_type r;
      r.kind     = kind;
      r.octave   = OCTAVE_BITS'(oct);
      r.semitone = SEMITONE_BITS'(semi);
      r.step     = step;
      return r;
   endfunction

   function automatic mixer_req_type tick_req();
      return make_req(REQ_TICK, $urandom_range(7), $urandom_range(15), $urandom);
   endfunction

   function automatic mixer_req_type random_req();
      mixer_req_type r;
      int pick;
      int voice;
      int sounding[$];
      r.kind     = REQ_TICK;
      r.octave   = OCTAVE_BITS'($urandom_range(NUM_OCT - 1));
      r.semitone = SEMITONE_BITS'($urandom_range(SEMITONES - 1));
      case ($urandom_range(3))
         0:       r.step = {8'($urandom_range(255)), 24'd0};
         1:       r.step = $urandom_range(32'h0400_0000);
         default: r.step = $urandom;
      endcase
      pick = $urandom_range(99);
      if (pick < 45) begin
         r.kind = REQ_TICK;
      end else if (pick < 69) begin
         r.kind = REQ_NOTE_ON;
      end else if (pick < 90) begin
         // mostly release a sounding voice so the bank does not fill up
         r.kind = REQ_NOTE_OFF;
         for (int n = 0; n < VOICE_COUNT; n++)
            if (voice_on[n]) sounding.push_back(n);
         if (sounding.size() != 0 && $urandom_range(9) != 0) begin
            voice = sounding[$urandom_range(sounding.size() - 1)];
            r.octave   = OCTAVE_BITS'(voice / SEMITONES);
            r.semitone = SEMITONE_BITS'(voice % SEMITONES);
         end
      end else if (pick < 96) begin
         r.kind = ($urandom_range(1) == 0) ? REQ_NOTE_ON : REQ_NOTE_OFF;
         r.semitone = SEMITONE_BITS'($urandom_range(15, SEMITONES));
      end else begin
         r.kind = REQ_UNUSED;
         r.semitone = SEMITONE_BITS'($urandom_range(15));
      end
      return r;
   endfunction

   // Called at a falling edge; returns at a falling edge after the transfer.
   task automatic send_req(input mixer_req_type r);
      logic [7:0] sample;
      req_push       <= 1'b1;
      req_type       <= r.kind;
      req_octave     <= r.octave;
      req_semitone   <= r.semitone;
      req_phase_step <= r.step;
      do @(posedge clock); while (req_full);
      if (mix_request(r, sample)) expected_samples.push_back(sample);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_req(tick_req());
   endtask

   // Hold requests until every sample is out, then let pending notes finish.
   task automatic settle_block();
      req_push <= 1'b0;
      do @(negedge clock); while (expected_samples.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         CSR_WAVE:   wave_cfg   = wave_type'(value[1:0]);
         CSR_VOLUME: volume_cfg = value[VOLUME_BITS-1:0];
         CSR_MUTE:   mute_cfg   = value[0];
         default:    ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_settings(input wave_type wave_sel, input logic [3:0] level,
                                 input logic silence);
      settle_block();
      write_csr(CSR_WAVE, 32'(wave_sel));
      write_csr(CSR_VOLUME, 32'(level));
      write_csr(CSR_MUTE, 32'(silence));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic test_note_handling();
      send_req(make_req(REQ_NOTE_ON, 0, 0, 32'h0100_0000));
      send_req(make_req(REQ_NOTE_ON, 7, 11, 32'hFFFF_FFFF));
      send_ticks(2);
      // out-of-range voices and the unused code are dropped
      send_req(make_req(REQ_NOTE_ON, 3, 12, 32'hDEAD_BEEF));
      send_req(make_req(REQ_NOTE_OFF, 7, 15, 32'h0));
      send_req(make_req(REQ_UNUSED, 7, 15, 32'hFFFF_FFFF));
      send_ticks(1);
      // new step on a sounding voice, accumulator kept
      send_req(make_req(REQ_NOTE_ON, 0, 0, 32'h4000_0000));
      send_ticks(1);
      send_req(make_req(REQ_NOTE_OFF, 7, 11, 32'h0));
      send_req(make_req(REQ_NOTE_OFF, 5, 6, 32'h0));
      send_ticks(1);
      send_req(make_req(REQ_NOTE_OFF, 0, 0, 32'h0));
      send_ticks(1);
      send_req(make_req(REQ_NOTE_ON, 0, 0, 32'h0));
      send_req(make_req(REQ_NOTE_ON, 2, 5, 32'h8000_0000));
      send_req(make_req(REQ_NOTE_ON, 4, 9, 32'h0080_0000));
      send_ticks(2);
      // released voice resumes from its kept accumulator
      send_req(make_req(REQ_NOTE_ON, 7, 11, 32'h0000_0001));
      send_ticks(1);
   endtask

   task automatic test_waveforms_and_volume();
      apply_settings(WAVE_SAW, VOLUME_TOP, 1'b0);
      send_req(make_req(REQ_NOTE_ON, 2, 7, 32'h0800_0000));
      send_req(make_req(REQ_NOTE_ON, 5, 11, 32'h1234_5678));
      send_req(make_req(REQ_NOTE_ON, 7, 0, 32'hF000_0000));
      send_ticks(2);
      apply_settings(WAVE_SQUARE, 4'd15, 1'b0);
      send_ticks(3);
      apply_settings(WAVE_TRIANGLE, 4'd0, 1'b0);
      send_ticks(2);
      apply_settings(WAVE_SINE, 4'd8, 1'b0);
      send_ticks(2);
   endtask

   task automatic test_mute();
      apply_settings(WAVE_TRIANGLE, VOLUME_TOP, 1'b1);
      send_ticks(3);
      send_req(make_req(REQ_NOTE_ON, 1, 3, 32'h2200_0000));
      send_ticks(2);
      // phases must not have moved while muted
      apply_settings(WAVE_TRIANGLE, VOLUME_TOP, 1'b0);
      send_ticks(3);
   endtask

   task automatic test_random_mix(input int count);
      int left;
      left = count;
      while (left > 0) begin
         apply_settings(wave_type'($urandom_range(3)), 4'($urandom_range(15)),
                        $urandom_range(7) == 0);
         repeat (SEGMENT_ITEMS) send_req(random_req());
         left -= SEGMENT_ITEMS;
      end
   endtask

   task automatic test_backpressure();
      apply_settings(WAVE_TRIANGLE, 4'd7, 1'b0);
      send_req(make_req(REQ_NOTE_ON, 1, 4, 32'h0123_4567));
      send_req(make_req(REQ_NOTE_ON, 6, 0, 32'h3000_0001));
      // stall the sample side long enough to back up both queues
      pop_hold_left = 400;
      send_ticks(24);
      req_push <= 1'b0;
      do @(negedge clock); while (expected_samples.size() != 0);
      send_ticks(8);
   endtask

   // sample side: random pops, plus long hold-offs on request
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (pop_hold_left > 0) begin
            pop_hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_samples
      logic [SAMPLE_BITS-1:0] want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected sample, expected none, actual %0d", $time, rsp_sample);
            mismatch_count++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample !== want) begin
               $display("%0t: sample mismatch, expected %0d, actual %0d",
                        $time, want, rsp_sample);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("tb_top failed");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_push       = 1'b0;
      req_type       = '0;
      req_octave     = '0;
      req_semitone   = '0;
      req_phase_step = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      mismatch_count = 0;
      pop_hold_left  = 0;
      send_idle_pct  = 13;
      recv_idle_pct  = 59;
      wave_cfg       = WAVE_RESET;
      volume_cfg     = VOLUME_RESET;
      mute_cfg       = 1'b0;
      for (int n = 0; n < VOICE_COUNT; n++) begin
         phase_acc[n] = '0;
         phase_inc[n] = '0;
         voice_on[n]  = 1'b0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_note_handling();
      test_waveforms_and_volume();
      test_mute();
      test_random_mix(520);

      send_idle_pct = 59;
      recv_idle_pct = 13;
      test_random_mix(520);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_mix(520);
      test_backpressure();

      req_push <= 1'b0;
      do @(negedge clock); while (expected_samples.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_samples.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/pwtm_pkg.sv
hdl/pwtm_fifo.sv
hdl/pwtm_front.sv
hdl/pwtm_wave_rom.sv
hdl/pwtm_engine.sv
hdl/polyphonic_wavetable_mixer_core.sv
tb/tb_top.sv
